// ===== hw/rtl/rcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the rgb colour fader
// Request layouts, command codes, time widths and sequencer states.
// ----------------------------------------------------------------------------
package rcf_pkg;

	// time counter width and derived widths
	localparam int TIME_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int CALC_W = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
	localparam int COL_W = 8;
	localparam int NUM_W = TIME_BITS + COL_W;
	localparam int STEPS = COL_W;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [COL_W-1:0] COL_WHITE = {COL_W{1'b1}};
	localparam logic [1:0] CH_LAST = 2'd2;

	// command codes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SET = 2'd1;
	localparam logic [1:0] MODE_SHOW = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [COL_W-1:0] chan_a;
		logic [COL_W-1:0] chan_b;
		logic [COL_W-1:0] chan_c;
		logic [FIELD_BITS-1:0] fade_ticks;
		logic [FIELD_BITS-1:0] elapsed_ticks;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0] out_a;
		logic [COL_W-1:0] out_b;
		logic [COL_W-1:0] out_c;
		logic fade_finished;
	} col_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/rgb_colour_fader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_colour_fader: three-channel linear colour fader
// Set, tick and refresh requests drive a linear fade between two colours;
// each channel is blended with a bit-serial multiply and a bit-serial divide.
// ----------------------------------------------------------------------------
//
//  port group        dir   request
//  cmd / cmd_valid    in   mode, goal colour, fade duration, elapsed time
//  col / col_valid    out  current colour and fade end flag
//
//  A tick during a fade runs, per channel, one load step, 8 multiply steps
//  and 8 divide steps, one bit each, through a single shared shift-add /
//  restoring-divide datapath, then passes the emit state. Refresh requests
//  and zero-duration set requests go straight to the emit state; other
//  requests give no result. cmd_stall stays high until the sequencer is idle.
//  A waiting result holds the sequencer in its emit state while col_stall is
//  high. Reset puts all colours at white and stops any fade.
//
module rgb_colour_fader (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  rcf_pkg::cmd_t    cmd,
	output logic             col_valid,
	input  logic             col_stall,
	output rcf_pkg::col_t    col
);

	rcf_pkg::state_t state_q;
	rcf_pkg::state_t state_next;

	logic [rcf_pkg::TIME_BITS-1:0] left_q;
	logic [rcf_pkg::TIME_BITS-1:0] total_q;
	logic [rcf_pkg::TIME_BITS-1:0] done_q;
	logic [rcf_pkg::COL_W-1:0]     start_q [3];
	logic [rcf_pkg::COL_W-1:0]     goal_q [3];
	logic [rcf_pkg::COL_W-1:0]     now_q [3];
	logic                          fading_q;
	logic                          finished_q;

	logic [1:0]                    ch_q;
	logic [rcf_pkg::CNT_W-1:0]     cnt_q;
	logic [rcf_pkg::COL_W-1:0]     s_sh_q;
	logic [rcf_pkg::COL_W-1:0]     d_sh_q;
	logic                          down_q;
	logic [rcf_pkg::NUM_W-1:0]     acc_q;

	logic                          col_valid_q;
	rcf_pkg::col_t                 col_q;

	logic                          cmd_take;
	logic                          can_emit;
	logic                          last_step;

	logic [rcf_pkg::CALC_W-1:0]    dur_ext;
	logic [rcf_pkg::CALC_W-1:0]    dt_ext;
	logic [rcf_pkg::CALC_W-1:0]    left_ext;
	logic [rcf_pkg::TIME_BITS-1:0] dur_sat;
	logic [rcf_pkg::TIME_BITS-1:0] left_new;

	logic [rcf_pkg::COL_W-1:0]     s_cur;
	logic [rcf_pkg::COL_W-1:0]     g_cur;

	logic [rcf_pkg::NUM_W-1:0]     mul_sh;
	logic [rcf_pkg::NUM_W-1:0]     t_add;
	logic [rcf_pkg::NUM_W-1:0]     d_add;
	logic [rcf_pkg::NUM_W-1:0]     acc_mul;

	logic [rcf_pkg::TIME_BITS:0]   trial;
	logic [rcf_pkg::TIME_BITS:0]   diff;
	logic                          qbit;
	logic [rcf_pkg::TIME_BITS-1:0] rem_new;
	logic [rcf_pkg::NUM_W-1:0]     acc_div;

	// handshake
	assign cmd_stall = (state_q != rcf_pkg::ST_IDLE);
	assign cmd_take = cmd_valid && !cmd_stall;
	assign can_emit = !col_valid_q || !col_stall;
	assign last_step = (cnt_q == rcf_pkg::CNT_W'(rcf_pkg::STEPS - 1));
	assign col_valid = col_valid_q;
	assign col = col_q;

	// duration saturation and remaining time update
	always_comb begin
		dur_ext = rcf_pkg::CALC_W'(cmd.fade_ticks);
		dt_ext = rcf_pkg::CALC_W'(cmd.elapsed_ticks);
		left_ext = rcf_pkg::CALC_W'(left_q);
		if (dur_ext > rcf_pkg::CALC_W'(rcf_pkg::TIME_MAX)) begin
			dur_sat = rcf_pkg::TIME_MAX;
		end else begin
			dur_sat = dur_ext[rcf_pkg::TIME_BITS-1:0];
		end
		if (dt_ext >= left_ext) begin
			left_new = '0;
		end else begin
			left_new = rcf_pkg::TIME_BITS'(left_ext - dt_ext);
		end
	end

	// selected channel
	assign s_cur = start_q[ch_q];
	assign g_cur = goal_q[ch_q];

	// multiply step, msb first: acc = 2*acc + s_bit*total +/- d_bit*done
	always_comb begin
		mul_sh = {acc_q[rcf_pkg::NUM_W-2:0], 1'b0};
		t_add = s_sh_q[rcf_pkg::COL_W-1] ? rcf_pkg::NUM_W'(total_q) : '0;
		d_add = d_sh_q[rcf_pkg::COL_W-1] ? rcf_pkg::NUM_W'(done_q) : '0;
		if (down_q) begin
			acc_mul = mul_sh + t_add - d_add;
		end else begin
			acc_mul = mul_sh + t_add + d_add;
		end
	end

	// restoring divide step, quotient bits shift in at the bottom
	always_comb begin
		trial = acc_q[rcf_pkg::NUM_W-1:rcf_pkg::COL_W-1];
		diff = trial - {1'b0, total_q};
		qbit = (trial >= {1'b0, total_q});
		rem_new = qbit ? diff[rcf_pkg::TIME_BITS-1:0] : trial[rcf_pkg::TIME_BITS-1:0];
		acc_div = {rem_new, acc_q[rcf_pkg::COL_W-2:0], qbit};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			rcf_pkg::ST_IDLE: begin
				if (cmd_take) begin
					unique case (cmd.mode)
						rcf_pkg::MODE_TICK: begin
							if (fading_q) begin
								state_next = rcf_pkg::ST_LOAD;
							end
						end
						rcf_pkg::MODE_SET: begin
							if (dur_sat == '0) begin
								state_next = rcf_pkg::ST_EMIT;
							end
						end
						rcf_pkg::MODE_SHOW: state_next = rcf_pkg::ST_EMIT;
						rcf_pkg::MODE_NONE: state_next = rcf_pkg::ST_IDLE;
					endcase
				end
			end
			rcf_pkg::ST_LOAD: state_next = rcf_pkg::ST_MUL;
			rcf_pkg::ST_MUL: begin
				if (last_step) begin
					state_next = rcf_pkg::ST_DIV;
				end
			end
			rcf_pkg::ST_DIV: begin
				if (last_step) begin
					if (ch_q == rcf_pkg::CH_LAST) begin
						state_next = rcf_pkg::ST_EMIT;
					end else begin
						state_next = rcf_pkg::ST_LOAD;
					end
				end
			end
			rcf_pkg::ST_EMIT: begin
				if (can_emit) begin
					state_next = rcf_pkg::ST_IDLE;
				end
			end
			default: state_next = rcf_pkg::ST_IDLE;
		endcase
	end

	// fade state and colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			total_q <= '0;
			fading_q <= 1'b0;
			finished_q <= 1'b0;
			ch_q <= '0;
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= rcf_pkg::COL_WHITE;
				goal_q[i] <= rcf_pkg::COL_WHITE;
				now_q[i] <= rcf_pkg::COL_WHITE;
			end
		end else begin
			if (state_q == rcf_pkg::ST_IDLE && cmd_take) begin
				unique case (cmd.mode)
					rcf_pkg::MODE_TICK: begin
						if (fading_q) begin
							left_q <= left_new;
							finished_q <= (left_new == '0);
							ch_q <= '0;
							if (left_new == '0) begin
								fading_q <= 1'b0;
							end
						end
					end
					rcf_pkg::MODE_SET: begin
						finished_q <= 1'b0;
						if (dur_sat != '0) begin
							fading_q <= 1'b1;
							left_q <= dur_sat;
							total_q <= dur_sat;
							goal_q[0] <= cmd.chan_a;
							goal_q[1] <= cmd.chan_b;
							goal_q[2] <= cmd.chan_c;
							for (int i = 0; i < 3; i++) begin
								start_q[i] <= now_q[i];
							end
						end else begin
							fading_q <= 1'b0;
							now_q[0] <= cmd.chan_a;
							now_q[1] <= cmd.chan_b;
							now_q[2] <= cmd.chan_c;
						end
					end
					rcf_pkg::MODE_SHOW: finished_q <= 1'b0;
					rcf_pkg::MODE_NONE: finished_q <= finished_q;
				endcase
			end
			// store the quotient and move to the next channel
			if (state_q == rcf_pkg::ST_DIV && last_step) begin
				now_q[ch_q] <= acc_div[rcf_pkg::COL_W-1:0];
				if (ch_q != rcf_pkg::CH_LAST) begin
					ch_q <= ch_q + 2'd1;
				end
			end
		end
	end

	// elapsed part of the fade, fixed for the whole tick
	always_ff @(posedge clk) begin
		if (state_q == rcf_pkg::ST_IDLE && cmd_take) begin
			done_q <= total_q - left_new;
		end
	end

	// serial blend datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (state_q == rcf_pkg::ST_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == rcf_pkg::ST_MUL || state_q == rcf_pkg::ST_DIV) begin
				cnt_q <= last_step ? '0 : cnt_q + rcf_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rcf_pkg::ST_LOAD) begin
			s_sh_q <= s_cur;
			down_q <= (g_cur < s_cur);
			d_sh_q <= (g_cur < s_cur) ? (s_cur - g_cur) : (g_cur - s_cur);
			acc_q <= '0;
		end else if (state_q == rcf_pkg::ST_MUL) begin
			s_sh_q <= {s_sh_q[rcf_pkg::COL_W-2:0], 1'b0};
			d_sh_q <= {d_sh_q[rcf_pkg::COL_W-2:0], 1'b0};
			acc_q <= acc_mul;
		end else if (state_q == rcf_pkg::ST_DIV) begin
			acc_q <= acc_div;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_valid_q <= 1'b0;
		end else begin
			if (state_q == rcf_pkg::ST_EMIT && can_emit) begin
				col_valid_q <= 1'b1;
			end else if (!col_stall) begin
				col_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rcf_pkg::ST_EMIT && can_emit) begin
			col_q.out_a <= now_q[0];
			col_q.out_b <= now_q[1];
			col_q.out_c <= now_q[2];
			col_q.fade_finished <= finished_q;
		end
	end

endmodule
